@@ rtl/olst_pkg.sv @@
// Shared constants, codes and types for the ordered list store.
package olst_pkg;

    // List geometry.
    localparam int CAPACITY  = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    // Operation codes.
    localparam logic [1:0] OP_APPEND    = 2'd0;
    localparam logic [1:0] OP_FIND      = 2'd1;
    localparam logic [1:0] OP_DEL_VALUE = 2'd2;
    localparam logic [1:0] OP_DEL_POS   = 2'd3;

    // Status codes.
    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;

    // Per-cell command from the controller.
    typedef struct packed {
        logic cmp_en;
        logic shift;
        logic load;
    } olst_cell_ctrl_t;

endpackage

@@ rtl/olst_cell.sv @@
// One list cell: holds an entry, compares it, and takes its upper neighbor's entry on a shift.
module olst_cell
    import olst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  olst_cell_ctrl_t       ctrl,
    input  logic [WORD_BITS-1:0]  word,
    input  logic                  live,
    input  logic [WORD_BITS-1:0]  nbr_entry,
    output logic [WORD_BITS-1:0]  entry,
    output logic                  match
);

    logic [WORD_BITS-1:0] entry_reg;
    logic                 match_reg;

    // Entry storage: a load writes the appended word, a shift closes a gap.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            entry_reg <= word;
        end
        else if (ctrl.shift)
        begin
            entry_reg <= nbr_entry;
        end
    end

    // Match flag, only for entries that hold a live value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else if (ctrl.cmp_en)
        begin
            match_reg <= live && (entry_reg == word);
        end
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

@@ rtl/olst_pick.sv @@
// Picks the lowest matching cell and encodes its position.
module olst_pick
    import olst_pkg::*;
(
    input  logic [CAPACITY-1:0] match_vec,
    output logic [CAPACITY-1:0] low_oh,
    output logic [IDX_BITS-1:0] low_pos,
    output logic                any
);

    // Isolate the lowest set bit.
    assign low_oh = match_vec & (~match_vec + CAPACITY'(1));
    assign any    = |match_vec;

    // Encode the one-hot position.
    always_comb
    begin
        low_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (low_oh[i])
            begin
                low_pos = low_pos | IDX_BITS'(i);
            end
        end
    end

endmodule

@@ rtl/ordered_list_store.sv @@
// Top level of the ordered list store: controller, cell chain and result register.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_ready     opcode, value, position_in
//   out      output     out_valid / out_ready   found, position_out, entry_count, status
//
// For each item, the accept edge registers the compare in every cell, and the edge
// that fires the apply step applies the operation across the cell chain and loads the result.
// The apply step waits while an earlier result is still held and not taken.
// Reset clears the count, the control state and the result valid flag; entries
// above the count are never read, so they are not cleared.
module ordered_list_store
    import olst_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] value,
    input  logic [5:0]         position_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               found,
    output logic [5:0]         position_out,
    output logic [6:0]         entry_count,
    output logic [1:0]         status
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_APPLY = 1'b1;

    logic                 state_reg, state_next;
    logic [1:0]           op_reg;
    logic [WORD_BITS-1:0] val_reg;
    logic [IDX_BITS-1:0]  pos_reg;
    logic [CNT_BITS-1:0]  count_reg, count_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg, found_next;
    logic [IDX_BITS-1:0]  pos_out_reg, pos_out_next;
    logic [1:0]           status_reg, status_next;

    logic                 accept;
    logic                 fire;
    logic [WORD_BITS-1:0] word;
    logic [CAPACITY-1:0]  live_vec;
    logic [CAPACITY-1:0]  match_vec;
    logic [CAPACITY-1:0]  low_oh;
    logic [IDX_BITS-1:0]  low_pos;
    logic                 any;
    logic [CAPACITY-1:0]  pos_oh;
    logic [CAPACITY-1:0]  tail_oh;
    logic [CAPACITY-1:0]  del_oh;
    logic [CAPACITY-1:0]  shift_vec;
    logic [CAPACITY-1:0]  load_vec;
    logic                 full;
    logic                 pos_ok;

    logic [WORD_BITS-1:0] entry_arr [CAPACITY];

    // Handshake.
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign fire     = (state_reg == S_APPLY) && (!out_valid_reg || out_ready);

    // Cells compare against the incoming word, and load the held word.
    assign word = (state_reg == S_IDLE) ? value[WORD_BITS-1:0] : val_reg;

    // Live mask and position decodes.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            live_vec[i] = CNT_BITS'(i) < count_reg;
            pos_oh[i]   = (pos_reg == IDX_BITS'(i));
            tail_oh[i]  = (count_reg[IDX_BITS-1:0] == IDX_BITS'(i));
        end
    end

    assign full   = (count_reg == CNT_BITS'(CAPACITY));
    assign pos_ok = {1'b0, pos_reg} < count_reg;

    olst_pick u_pick (
        .match_vec (match_vec),
        .low_oh    (low_oh),
        .low_pos   (low_pos),
        .any       (any)
    );

    // Operation decode for the apply step.
    always_comb
    begin
        del_oh       = '0;
        load_vec     = '0;
        count_next   = count_reg;
        found_next   = 1'b0;
        pos_out_next = '0;
        status_next  = STAT_DONE;
        unique case (op_reg)
            OP_APPEND:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    load_vec   = tail_oh;
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            OP_FIND:
            begin
                if (any)
                begin
                    found_next   = 1'b1;
                    pos_out_next = low_pos;
                end
                else
                begin
                    status_next = STAT_MISS;
                end
            end
            OP_DEL_VALUE:
            begin
                if (any)
                begin
                    found_next = 1'b1;
                    del_oh     = low_oh;
                    count_next = count_reg - CNT_BITS'(1);
                end
                else
                begin
                    status_next = STAT_MISS;
                end
            end
            OP_DEL_POS:
            begin
                if (pos_ok)
                begin
                    found_next = 1'b1;
                    del_oh     = pos_oh;
                    count_next = count_reg - CNT_BITS'(1);
                end
                else
                begin
                    status_next = STAT_MISS;
                end
            end
            default:
            begin
                status_next = STAT_MISS;
            end
        endcase
    end

    // Every cell at or above the removed position takes its neighbor's entry.
    assign shift_vec = ~(del_oh - CAPACITY'(1));

    // Cell chain.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            olst_cell_ctrl_t      cell_ctrl;
            logic [WORD_BITS-1:0] nbr;

            assign cell_ctrl = '{cmp_en: accept,
                                 shift:  fire && shift_vec[g],
                                 load:   fire && load_vec[g]};

            if (g == CAPACITY - 1)
            begin : g_last
                assign nbr = '0;
            end
            else
            begin : g_mid
                assign nbr = entry_arr[g+1];
            end

            olst_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .word      (word),
                .live      (live_vec[g]),
                .nbr_entry (nbr),
                .entry     (entry_arr[g]),
                .match     (match_vec[g])
            );
        end
    endgenerate

    // Control sequencing.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            state_next = S_APPLY;
        end
        else if (fire)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Item and result holding registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            val_reg <= value[WORD_BITS-1:0];
            pos_reg <= position_in;
        end
        if (fire)
        begin
            found_reg   <= found_next;
            pos_out_reg <= pos_out_next;
            status_reg  <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign position_out = pos_out_reg;
    assign entry_count  = count_reg;
    assign status       = status_reg;

    // A successful append grows the list by exactly one.
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (op_reg == OP_APPEND) && !full |=> count_reg == $past(count_reg) + CNT_BITS'(1))
        else $error("append did not grow the count");

    // A successful delete shrinks the list by exactly one.
    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        fire && found_next && ((op_reg == OP_DEL_VALUE) || (op_reg == OP_DEL_POS))
        |=> count_reg == $past(count_reg) - CNT_BITS'(1))
        else $error("delete did not shrink the count");

    // The picker never selects more than one cell.
    a_pick_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(low_oh))
        else $error("more than one cell picked");

    // Matches only come from live entries.
    a_match_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> ((match_vec & ~live_vec) == '0))
        else $error("match flagged above the count");

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the ordered list store: directed table, then random traffic.
`timescale 1ns / 100ps

module testbench;
    import olst_pkg::*;

    // One result item of the store.
    typedef struct packed {
        logic       found;
        logic [5:0] position_out;
        logic [6:0] entry_count;
        logic [1:0] status;
    } list_result_t;

    // One row of the directed table; the result is only used when typed is set.
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
        logic [5:0]         position_in;
        logic               typed;
        list_result_t       result;
    } list_row_t;

    // Traffic shape of the random part.
    typedef enum logic {
        MODE_FILL,
        MODE_DRAIN
    } traffic_mode_t;

    localparam int DIRECTED_ROWS = 24;
    localparam int PHASE_ITEMS   = 180;
    localparam int PHASES        = 8;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode = OP_APPEND;
    logic signed [31:0] value = '0;
    logic [5:0]         position_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               found;
    logic [5:0]         position_out;
    logic [6:0]         entry_count;
    logic [1:0]         status;

    // Shadow copy of the list and the results still owed by the store.
    logic signed [31:0] shadow_words [CAPACITY];
    int                 shadow_count = 0;
    list_result_t       pending_results [$];
    int                 fail_count = 0;

    // Current item's typed expectation, if any.
    logic               cur_typed = 1'b0;
    list_result_t       cur_result = '0;

    // Idle and stall rates in percent.
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    traffic_mode_t      traffic_mode = MODE_FILL;

    int                 phase_idle [4] = '{0, 56, 0, 15};
    int                 phase_stall [4] = '{0, 0, 56, 15};

    // Directed rows: empty list misses, extremes, duplicates, gap closing.
    list_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_FIND,      32'h0000_0000, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd0, STAT_MISS}},
        '{OP_DEL_VALUE, 32'h0000_0000, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd0, STAT_MISS}},
        '{OP_DEL_POS,   32'h0000_0000, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd0, STAT_MISS}},
        '{OP_DEL_POS,   32'h0000_0000, 6'd63, 1'b1, '{1'b0, 6'd0, 7'd0, STAT_MISS}},
        '{OP_APPEND,    32'h7FFF_FFFF, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd1, STAT_DONE}},
        '{OP_APPEND,    32'h8000_0000, 6'd63, 1'b1, '{1'b0, 6'd0, 7'd2, STAT_DONE}},
        '{OP_APPEND,    32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd3, STAT_DONE}},
        '{OP_APPEND,    32'h0000_0000, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd4, STAT_DONE}},
        '{OP_APPEND,    32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd5, STAT_DONE}},
        '{OP_FIND,      32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b1, 6'd2, 7'd5, STAT_DONE}},
        '{OP_FIND,      32'h8000_0000, 6'd0,  1'b1, '{1'b1, 6'd1, 7'd5, STAT_DONE}},
        '{OP_FIND,      32'h0000_0007, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd5, STAT_MISS}},
        '{OP_DEL_VALUE, 32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b1, 6'd0, 7'd4, STAT_DONE}},
        '{OP_FIND,      32'hFFFF_FFFF, 6'd0,  1'b1, '{1'b1, 6'd3, 7'd4, STAT_DONE}},
        '{OP_DEL_POS,   32'h0000_0000, 6'd4,  1'b1, '{1'b0, 6'd0, 7'd4, STAT_MISS}},
        '{OP_DEL_POS,   32'h0000_0000, 6'd0,  1'b1, '{1'b1, 6'd0, 7'd3, STAT_DONE}},
        '{OP_FIND,      32'h8000_0000, 6'd0,  1'b1, '{1'b1, 6'd0, 7'd3, STAT_DONE}},
        '{OP_DEL_POS,   32'h0000_0000, 6'd2,  1'b1, '{1'b1, 6'd0, 7'd2, STAT_DONE}},
        '{OP_DEL_VALUE, 32'h0000_0005, 6'd0,  1'b1, '{1'b0, 6'd0, 7'd2, STAT_MISS}},
        '{OP_FIND,      32'h0000_0000, 6'd0,  1'b1, '{1'b1, 6'd1, 7'd2, STAT_DONE}},
        '{OP_APPEND,    32'h5555_5555, 6'd0,  1'b0, '0},
        '{OP_APPEND,    32'hAAAA_AAAA, 6'd0,  1'b0, '0},
        '{OP_FIND,      32'hAAAA_AAAA, 6'd0,  1'b0, '0},
        '{OP_DEL_VALUE, 32'h5555_5555, 6'd0,  1'b0, '0}
    };

    ordered_list_store dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .value        (value),
        .position_in  (position_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .found        (found),
        .position_out (position_out),
        .entry_count  (entry_count),
        .status       (status)
    );

    // Clock.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    // Remove one entry from the shadow list and close the gap.
    function automatic void shadow_remove(input int where);
        for (int i = where; i + 1 < shadow_count; i++)
        begin
            shadow_words[i] = shadow_words[i + 1];
        end
        shadow_count--;
    endfunction

    // Apply one operation to the shadow list and return the result it should give.
    function automatic list_result_t apply_list_op(input logic [1:0] op,
                                                   input logic signed [31:0] word,
                                                   input logic [5:0] where_in);
        list_result_t res;
        int           hit;
        res = '0;
        res.status = STAT_DONE;
        hit = -1;
        for (int i = 0; i < shadow_count; i++)
        begin
            if (hit < 0 && shadow_words[i] == word)
            begin
                hit = i;
            end
        end
        case (op)
            OP_APPEND:
            begin
                if (shadow_count >= CAPACITY)
                begin
                    res.status = STAT_FULL;
                end
                else
                begin
                    shadow_words[shadow_count] = word;
                    shadow_count++;
                end
            end
            OP_FIND:
            begin
                if (hit >= 0)
                begin
                    res.found = 1'b1;
                    res.position_out = hit[5:0];
                end
                else
                begin
                    res.status = STAT_MISS;
                end
            end
            OP_DEL_VALUE:
            begin
                if (hit >= 0)
                begin
                    res.found = 1'b1;
                    shadow_remove(hit);
                end
                else
                begin
                    res.status = STAT_MISS;
                end
            end
            default:
            begin
                if (int'(where_in) < shadow_count)
                begin
                    res.found = 1'b1;
                    shadow_remove(int'(where_in));
                end
                else
                begin
                    res.status = STAT_MISS;
                end
            end
        endcase
        res.entry_count = shadow_count[6:0];
        return res;
    endfunction

    // Check results against the oldest expectation, then record newly accepted items.
    always @(posedge clk)
    begin
        list_result_t exp_res;
        list_result_t predicted;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("Result item arrived with no expectation waiting.");
                    fail_count++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    if (found !== exp_res.found)
                    begin
                        $error("found: expected %0d, actual %0d", exp_res.found, found);
                        fail_count++;
                    end
                    if (position_out !== exp_res.position_out)
                    begin
                        $error("position_out: expected %0d, actual %0d",
                               exp_res.position_out, position_out);
                        fail_count++;
                    end
                    if (entry_count !== exp_res.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               exp_res.entry_count, entry_count);
                        fail_count++;
                    end
                    if (status !== exp_res.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_res.status, status);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                predicted = apply_list_op(opcode, value, position_in);
                pending_results.push_back(cur_typed ? cur_result : predicted);
            end
        end
    end

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Present one item and hold it until the store accepts it; returns at a falling edge.
    task automatic send_item(input logic [1:0] op, input logic signed [31:0] word,
                             input logic [5:0] where_in, input logic typed,
                             input list_result_t typed_res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        value       <= word;
        position_in <= where_in;
        cur_typed   = typed;
        cur_result  = typed_res;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Drop valid and wait until every owed result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // A word that often matches the list: a stored entry, a small value, an extreme or noise.
    function automatic logic signed [31:0] pick_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3 && shadow_count > 0)
        begin
            return shadow_words[$urandom_range(0, shadow_count - 1)];
        end
        if (pick <= 5)
        begin
            return $signed($urandom_range(0, 8)) - 4;
        end
        if (pick == 6)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    // One random item: mostly fill-to-full or drain-to-empty traffic, with some noise.
    task automatic random_item();
        logic [1:0]         op;
        logic signed [31:0] word;
        logic [5:0]         where_in;
        int                 roll;
        if (traffic_mode == MODE_FILL && shadow_count == CAPACITY && $urandom_range(0, 3) == 0)
        begin
            traffic_mode = MODE_DRAIN;
        end
        else if (traffic_mode == MODE_DRAIN && shadow_count == 0 && $urandom_range(0, 2) == 0)
        begin
            traffic_mode = MODE_FILL;
        end
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) == 0)
        begin
            op       = 2'($urandom_range(0, 3));
            word     = $urandom;
            where_in = 6'($urandom_range(0, 63));
        end
        else
        begin
            if (traffic_mode == MODE_FILL)
            begin
                op = (roll < 60) ? OP_APPEND : (roll < 80) ? OP_FIND :
                     (roll < 90) ? OP_DEL_VALUE : OP_DEL_POS;
            end
            else
            begin
                op = (roll < 10) ? OP_APPEND : (roll < 30) ? OP_FIND :
                     (roll < 65) ? OP_DEL_VALUE : OP_DEL_POS;
            end
            word = pick_word();
            if (shadow_count > 0 && $urandom_range(0, 3) != 0)
            begin
                where_in = 6'($urandom_range(0, shadow_count - 1));
            end
            else
            begin
                where_in = 6'($urandom_range(0, 63));
            end
        end
        send_item(op, word, where_in, 1'b0, '0);
    endtask

    // Main sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            send_item(directed_rows[r].opcode, directed_rows[r].value,
                      directed_rows[r].position_in, directed_rows[r].typed,
                      directed_rows[r].result);
        end
        drain_results();

        // Random phases under each idling pattern; every owed result returns between phases.
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct = phase_idle[p % 4];
            stall_pct     = phase_stall[p % 4];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_item();
            end
            drain_results();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/olst_pkg.sv
rtl/olst_cell.sv
rtl/olst_pick.sv
rtl/ordered_list_store.sv
bench/testbench.sv
